>>> rtl/assert_macros.svh
// Assertion macros shared by the exponentiation RTL.
// Needs no other file; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/gfm_pkg.sv
// Shared constants and controller state type for the GF(2^n) exponentiator.
// No dependencies.
package gfm_pkg;

    localparam int unsigned MAX_FIELD_DEGREE_DEF = 63;
    localparam int unsigned BASE_W    = 64;
    localparam int unsigned EXP_W     = 64;
    localparam int unsigned POW_W     = 63;
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned S_TDATA_W = ((BASE_W + EXP_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W = ((POW_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RED_GO,
        ST_RED,
        ST_MUL_GO,
        ST_MUL,
        ST_OUT
    } gfm_state_t;

endpackage

>>> rtl/gfm_reduce.sv
// Bit-serial remainder of the base polynomial modulo the field polynomial.
// Uses gfm_pkg and assert_macros.svh; one base bit enters per cycle, MSB first.
`include "assert_macros.svh"
module gfm_reduce
    import gfm_pkg::*;
#(
    parameter int unsigned FW = MAX_FIELD_DEGREE_DEF + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [BASE_W-1:0] base,
    input  logic [FW-1:0]     fpoly,
    input  logic [FW-1:0]     nbit_mask,
    output logic              done,
    output logic [FW-1:0]     rem
);

    localparam int unsigned CNT_W = $clog2(BASE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BASE_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BASE_W-1:0] sh_reg, sh_next;
    logic [FW-1:0]     rem_reg, rem_next;
    logic [FW-1:0]     rem_shift;

    // Shift in the next base bit and cancel bit n when it appears
    always_comb begin
        rem_shift = {rem_reg[FW-2:0], sh_reg[BASE_W-1]};
        if (|(rem_shift & nbit_mask)) begin
            rem_shift = rem_shift ^ fpoly;
        end
    end

    // Sequence one reduction pass
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = base;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = rem_shift;
            sh_next  = {sh_reg[BASE_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    `ASSERT_IMPLY(a_red_start_idle, aclk, aresetn, start, !busy_reg, "reduce restarted while busy")
    `ASSERT_IMPLY(a_red_rem_bound, aclk, aresetn, busy_reg, (rem_reg & ~(nbit_mask - FW'(1))) == '0, "remainder reached field degree")

endmodule

>>> rtl/gfm_mul.sv
// Bit-serial GF(2^n) multiplier with two lanes sharing one multiplier shift
// register: result*factor and factor*factor. Uses gfm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module gfm_mul
    import gfm_pkg::*;
#(
    parameter int unsigned FW = MAX_FIELD_DEGREE_DEF + 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [FW-1:0] a_res,
    input  logic [FW-1:0] a_fac,
    input  logic [FW-1:0] fpoly,
    input  logic [FW-1:0] top_mask,
    output logic          done,
    output logic [FW-1:0] prod_res,
    output logic [FW-1:0] prod_sq
);

    logic          busy_reg, busy_next;
    logic [FW-1:0] b_reg, b_next;
    logic [FW-1:0] acc_res_reg, acc_res_next;
    logic [FW-1:0] acc_sq_reg, acc_sq_next;
    logic [FW-1:0] sum_res_reg, sum_res_next;
    logic [FW-1:0] sum_sq_reg, sum_sq_next;

    // Finish once every multiplier bit has been consumed
    assign done = busy_reg && (b_reg == '0);

    // One multiplier bit per cycle: add, then double the multiplicands mod p
    always_comb begin
        busy_next    = busy_reg;
        b_next       = b_reg;
        acc_res_next = acc_res_reg;
        acc_sq_next  = acc_sq_reg;
        sum_res_next = sum_res_reg;
        sum_sq_next  = sum_sq_reg;
        if (start) begin
            busy_next    = 1'b1;
            b_next       = a_fac;
            acc_res_next = a_res;
            acc_sq_next  = a_fac;
            sum_res_next = '0;
            sum_sq_next  = '0;
        end else if (done) begin
            busy_next = 1'b0;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                sum_res_next = sum_res_reg ^ acc_res_reg;
                sum_sq_next  = sum_sq_reg ^ acc_sq_reg;
            end
            b_next       = b_reg >> 1;
            acc_res_next = {acc_res_reg[FW-2:0], 1'b0}
                         ^ ((|(acc_res_reg & top_mask)) ? fpoly : '0);
            acc_sq_next  = {acc_sq_reg[FW-2:0], 1'b0}
                         ^ ((|(acc_sq_reg & top_mask)) ? fpoly : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        b_reg       <= b_next;
        acc_res_reg <= acc_res_next;
        acc_sq_reg  <= acc_sq_next;
        sum_res_reg <= sum_res_next;
        sum_sq_reg  <= sum_sq_next;
    end

    assign prod_res = sum_res_reg;
    assign prod_sq  = sum_sq_reg;

    `ASSERT_IMPLY(a_mul_start_idle, aclk, aresetn, start, !busy_reg, "multiply restarted while busy")
    `ASSERT_IMPLY(a_mul_acc_bound, aclk, aresetn, busy_reg, ((acc_res_reg | acc_sq_reg) & ~((top_mask << 1) - FW'(1))) == '0, "multiplicand left the field")

endmodule

>>> rtl/gf2n_modular_exponentiation.sv
// GF(2^n) modular exponentiation: top level with controller, degree scan,
// output register. Uses gfm_pkg, gfm_reduce, gfm_mul and assert_macros.svh.
//
// Computes base_poly ** exponent modulo the field polynomial written on the
// cfg port (bits above MAX_FIELD_DEGREE are dropped). One item is worked at a
// time. An exponent of zero returns 1. Otherwise the block scans the field
// polynomial from its top bit down for the degree n (one bit a cycle),
// reduces the base bit-serially, then runs one square-and-multiply step per
// exponent bit up to its highest set bit. Each step is one pass of the
// bit-serial multiplier, which walks the bits of the current factor.
// A field polynomial of degree below 1 with a nonzero exponent yields 0 with
// the bad_modulus flag set. The next item is taken while a finished result
// still waits in the output register.
`include "assert_macros.svh"
module gf2n_modular_exponentiation
    import gfm_pkg::*;
#(
    parameter int unsigned MAX_FIELD_DEGREE = MAX_FIELD_DEGREE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write: field_poly
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    // input beat
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [63:0] base_poly, [127:64] exponent
    // result beat
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [62:0] power_poly, [63] zero
    output logic                 m_tuser    // [0] bad_modulus
);

    localparam int unsigned FW    = MAX_FIELD_DEGREE + 1;
    localparam int unsigned DEG_W = $clog2(FW);

    gfm_state_t        state_reg, state_next;
    logic [FW-1:0]     field_poly_reg;
    logic [BASE_W-1:0] base_reg;
    logic [EXP_W-1:0]  exp_reg;
    logic [DEG_W-1:0]  deg_reg;
    logic [FW-1:0]     result_reg;
    logic [FW-1:0]     factor_reg;
    logic              bad_pend_reg;
    logic              out_valid_reg;
    logic [POW_W-1:0]  power_reg;
    logic              bad_reg;

    logic              in_beat;
    logic              out_load;
    logic              red_start;
    logic              mul_start;
    logic              red_done;
    logic              mul_done;
    logic [FW-1:0]     red_rem;
    logic [FW-1:0]     prod_res;
    logic [FW-1:0]     prod_sq;
    logic [FW-1:0]     top_mask;
    logic [FW-1:0]     nbit_mask;
    logic              exp_zero;
    logic              exp_last;

    assign in_beat   = s_tvalid && s_tready;
    assign exp_zero  = (s_tdata[BASE_W +: EXP_W] == '0);
    assign exp_last  = (exp_reg[EXP_W-1:1] == '0);
    assign top_mask  = FW'(1) << (deg_reg - DEG_W'(1));
    assign nbit_mask = FW'(1) << deg_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = exp_zero ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (field_poly_reg[deg_reg]) begin
                    state_next = ST_RED_GO;
                end else if (deg_reg == DEG_W'(1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_RED_GO: state_next = ST_RED;
            ST_RED: begin
                if (red_done) begin
                    state_next = ST_MUL_GO;
                end
            end
            ST_MUL_GO: state_next = ST_MUL;
            ST_MUL: begin
                if (mul_done) begin
                    state_next = exp_last ? ST_OUT : ST_MUL_GO;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Controller outputs
    always_comb begin
        s_tready  = 1'b0;
        red_start = 1'b0;
        mul_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready  = 1'b1;
            ST_RED_GO: red_start = 1'b1;
            ST_MUL_GO: mul_start = 1'b1;
            ST_OUT:    out_load  = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    // Control registers and field polynomial
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            field_poly_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                field_poly_reg <= cfg_data[FW-1:0];
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item datapath: capture, degree scan, square-and-multiply updates, output load
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            base_reg     <= s_tdata[BASE_W-1:0];
            exp_reg      <= s_tdata[BASE_W +: EXP_W];
            deg_reg      <= DEG_W'(MAX_FIELD_DEGREE);
            result_reg   <= FW'(1);
            bad_pend_reg <= 1'b0;
        end
        if (state_reg == ST_SCAN && !field_poly_reg[deg_reg]) begin
            if (deg_reg == DEG_W'(1)) begin
                result_reg   <= '0;
                bad_pend_reg <= 1'b1;
            end else begin
                deg_reg <= deg_reg - DEG_W'(1);
            end
        end
        if (state_reg == ST_RED && red_done) begin
            factor_reg <= red_rem;
        end
        if (state_reg == ST_MUL && mul_done) begin
            if (exp_reg[0]) begin
                result_reg <= prod_res;
            end
            factor_reg <= prod_sq;
            exp_reg    <= exp_reg >> 1;
        end
        if (out_load) begin
            power_reg <= POW_W'(result_reg[FW-2:0]);
            bad_reg   <= bad_pend_reg;
        end
    end

    gfm_reduce #(
        .FW (FW)
    ) u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (red_start),
        .base      (base_reg),
        .fpoly     (field_poly_reg),
        .nbit_mask (nbit_mask),
        .done      (red_done),
        .rem       (red_rem)
    );

    gfm_mul #(
        .FW (FW)
    ) u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mul_start),
        .a_res    (result_reg),
        .a_fac    (factor_reg),
        .fpoly    (field_poly_reg),
        .top_mask (top_mask),
        .done     (mul_done),
        .prod_res (prod_res),
        .prod_sq  (prod_sq)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = M_TDATA_W'(power_reg);
    assign m_tuser   = bad_reg;

    `ASSERT_NEXT(a_top_accept_busy, aclk, aresetn, in_beat, state_reg != ST_IDLE, "accepted beat did not start work")
    `ASSERT_IMPLY(a_top_bad_zero, aclk, aresetn, out_valid_reg && bad_reg, power_reg == '0, "bad modulus with nonzero power")
    `ASSERT_IMPLY(a_top_one_unit, aclk, aresetn, red_start || mul_start, state_reg == ST_RED_GO || state_reg == ST_MUL_GO, "unit started outside its launch state")

endmodule

>>> dv/tb_gf2n_modular_exponentiation.sv
// Self-checking testbench for gf2n_modular_exponentiation: drives operand beats
// and field polynomial writes, predicts each power in GF(2)[x], checks results.
// Depends on gfm_pkg and the gf2n_modular_exponentiation RTL only.
module tb_gf2n_modular_exponentiation;
    import gfm_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 1950;
    localparam int unsigned CALM_ITEMS    = 200;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned DRAIN_CYCLES  = 200;
    localparam int unsigned MAX_REPORTS   = 10;

    typedef struct packed {
        logic [EXP_W-1:0]  exponent;
        logic [BASE_W-1:0] base_poly;
    } operand_pair_t;

    typedef struct packed {
        logic             bad_modulus;
        logic [POW_W-1:0] power_poly;
    } power_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // [63:0] base_poly, [127:64] exponent
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [62:0] power_poly, [63] zero
    logic                 m_tuser;          // [0] bad_modulus

    operand_pair_t pending_operands[$];
    power_result_t expected_powers[$];
    operand_pair_t next_pair;
    operand_pair_t taken_pair;
    power_result_t seen_power;
    power_result_t want_power;

    logic [CFG_W-1:0] field_model = '0;
    logic             operand_taken = 1'b0;
    logic             calm = 1'b0;
    int unsigned      src_idle = 0;
    int unsigned      sink_idle = 0;
    int unsigned      operands_taken = 0;
    int unsigned      powers_checked = 0;
    int unsigned      bad_modulus_seen = 0;
    int unsigned      zero_exponent_seen = 0;
    int unsigned      field_writes = 0;
    int unsigned      mismatches = 0;
    int unsigned      orphans = 0;

    gf2n_modular_exponentiation u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor
    function automatic int unsigned gf_degree(input logic [CFG_W-1:0] p);
        int unsigned d = 0;
        for (int i = 1; i < CFG_W; i++) begin
            if (p[i]) begin
                d = i;
            end
        end
        return d;
    endfunction

    // Remainder of p modulo m, m of degree n >= 1
    function automatic logic [63:0] gf_reduce(input logic [63:0] p, input logic [63:0] m,
                                              input int n);
        for (int i = 63; i >= n; i--) begin
            if (p[i]) begin
                p ^= m << (i - n);
            end
        end
        return p;
    endfunction

    // Shift-and-add product of reduced operands, folding m in on carry out of bit n-1
    function automatic logic [63:0] gf_mul(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] m, input int n);
        logic [63:0] acc = a;
        logic [63:0] res = '0;
        for (int k = 0; k < 64; k++) begin
            if (b[k]) begin
                res ^= acc;
            end
            if (acc[n-1]) begin
                acc = (acc << 1) ^ m;
            end else begin
                acc = acc << 1;
            end
        end
        return res;
    endfunction

    // Right-to-left square-and-multiply over the current field polynomial
    function automatic power_result_t predict_power(input logic [CFG_W-1:0] field,
                                                    input operand_pair_t pair);
        power_result_t r;
        logic [63:0]   acc_pow = 64'd1;
        logic [63:0]   factor;
        int            n;
        n = gf_degree(field);
        if (pair.exponent == '0) begin
            r.power_poly  = POW_W'(1);
            r.bad_modulus = 1'b0;
            return r;
        end
        if (n < 1) begin
            r.power_poly  = '0;
            r.bad_modulus = 1'b1;
            return r;
        end
        factor = gf_reduce(pair.base_poly, field, n);
        for (int k = 0; k < EXP_W; k++) begin
            if (pair.exponent[k]) begin
                acc_pow = gf_mul(acc_pow, factor, field, n);
            end
            factor = gf_mul(factor, factor, field, n);
        end
        r.power_poly  = acc_pow[POW_W-1:0];
        r.bad_modulus = 1'b0;
        return r;
    endfunction

    // ---------------------------------------------------------------- driver side
    // Present operand beats from the pending queue, with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || operand_taken) begin
            if (src_idle != 0) begin
                src_idle <= src_idle - 1;
                s_tvalid <= 1'b0;
            end else if (pending_operands.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                src_idle <= $urandom_range(0, 2);
                s_tvalid <= 1'b0;
            end else begin
                next_pair = pending_operands.pop_front();
                s_tdata  <= next_pair;
                s_tvalid <= 1'b1;
            end
        end
    end

    // Stall the result channel in short random bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_idle != 0) begin
            sink_idle <= sink_idle - 1;
            m_tready  <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            sink_idle <= $urandom_range(0, 2);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge aclk) begin
        operand_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            // track field polynomial writes
            if (cfg_valid && cfg_ready) begin
                field_model = cfg_data;
            end
            // predict on every accepted operand beat
            if (s_tvalid && s_tready) begin
                taken_pair = s_tdata;
                want_power = predict_power(field_model, taken_pair);
                expected_powers.insert(expected_powers.size(), want_power);
                operands_taken++;
                if (taken_pair.exponent == '0) begin
                    zero_exponent_seen++;
                end
                if (want_power.bad_modulus) begin
                    bad_modulus_seen++;
                end
            end
            // compare each result beat with the oldest prediction
            if (m_tvalid && m_tready) begin
                seen_power = {m_tuser, m_tdata[POW_W-1:0]};
                if (expected_powers.size() == 0) begin
                    orphans++;
                    if (mismatches + orphans <= MAX_REPORTS) begin
                        $display("ERROR: result beat with nothing expected: power %h bad %b",
                                 seen_power.power_poly, seen_power.bad_modulus);
                    end
                end else begin
                    want_power = expected_powers.pop_front();
                    powers_checked++;
                    if (seen_power !== want_power) begin
                        mismatches++;
                        if (mismatches + orphans <= MAX_REPORTS) begin
                            $display("ERROR: result %0d: power exp %h got %h, bad exp %b got %b",
                                     powers_checked, want_power.power_poly,
                                     seen_power.power_poly, want_power.bad_modulus,
                                     seen_power.bad_modulus);
                        end
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic queue_item(input logic [63:0] base, input logic [63:0] expo);
        operand_pair_t p;
        p.base_poly = base;
        p.exponent  = expo;
        pending_operands.insert(pending_operands.size(), p);
    endtask

    // Hold until every queued operand is taken and every result is back
    task automatic settle();
        while (pending_operands.size() != 0 || s_tvalid || expected_powers.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_field(input logic [CFG_W-1:0] poly);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= poly;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
        field_writes++;
    endtask

    localparam logic [63:0] ALL_ONES = '1;
    localparam logic [63:0] TOP_BIT  = 64'h8000_0000_0000_0000;

    initial begin
        int unsigned random_items;
        int unsigned pick;
        int unsigned deg;
        int unsigned width;
        int unsigned count;
        logic [63:0] poly;
        logic [63:0] base;
        logic [63:0] expo;

        random_items = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // modulus left at reset value zero: degree below one
        queue_item(ALL_ONES, 64'd0);
        queue_item(64'd5, 64'd1);
        queue_item(64'd0, ALL_ONES);

        // constant modulus: still degree zero
        write_field(64'd1);
        queue_item(64'd3, 64'd2);
        queue_item(ALL_ONES, 64'd0);

        // degree one field
        write_field(64'd2);
        queue_item(ALL_ONES, 64'd1);
        queue_item(64'd0, 64'd5);
        queue_item(64'd1, ALL_ONES);

        // x^4 + x + 1: base equal to the modulus, order of x, extremes
        write_field(64'h13);
        queue_item(64'h13, 64'd3);
        queue_item(64'd2, 64'd15);
        queue_item(ALL_ONES, ALL_ONES);
        queue_item(64'd0, 64'd0);
        queue_item(64'd1, TOP_BIT);
        queue_item(64'hF, 64'd2);

        // all-ones modulus of the largest degree
        write_field(ALL_ONES);
        queue_item(ALL_ONES, 64'd1);
        queue_item(ALL_ONES, ALL_ONES);
        queue_item(TOP_BIT, 64'd3);
        queue_item(~TOP_BIT, 64'd2);

        // sparse modulus of the largest degree
        write_field(TOP_BIT | 64'h1B);
        queue_item(64'd2, 64'd63);
        queue_item(ALL_ONES, TOP_BIT);

        // random phases: mostly small fields, a few wide or degenerate ones
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                poly = 64'($urandom_range(0, 1));
            end else if (pick == 1) begin
                poly = 64'd2 | 64'($urandom_range(0, 1));
            end else begin
                if (pick == 2) begin
                    deg = 63;
                end else if (pick <= 4) begin
                    deg = $urandom_range(17, 62);
                end else begin
                    deg = $urandom_range(2, 16);
                end
                poly = {$urandom, $urandom};
                poly = (poly & ((64'd1 << deg) - 1)) | (64'd1 << deg);
            end
            if (random_items + CALM_ITEMS >= RANDOM_ITEMS) begin
                calm = 1'b1;
            end
            write_field(poly);
            deg = gf_degree(poly);
            count = (deg > 16) ? $urandom_range(15, 50) : $urandom_range(40, 150);
            // trim the last phase to the item budget
            if (count > RANDOM_ITEMS - random_items) begin
                count = RANDOM_ITEMS - random_items;
            end
            repeat (count) begin
                pick = $urandom_range(0, 9);
                base = {$urandom, $urandom};
                if (pick == 0) begin
                    base = base & ((64'd1 << deg) - 1);
                end else if (pick == 1) begin
                    base = ($urandom_range(0, 1) == 0) ? 64'd0 : ALL_ONES;
                end
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    expo = {$urandom, $urandom};
                end else if (pick == 1) begin
                    expo = 64'd0;
                end else begin
                    width = $urandom_range(1, (deg > 16) ? 6 : 14);
                    expo = {$urandom, $urandom};
                    expo = (expo & ((64'd1 << width) - 1)) | (64'd1 << (width - 1));
                end
                queue_item(base, expo);
                random_items++;
            end
        end

        // drain, then watch for stray result beats
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d results from %0d operand beats over %0d field polynomial writes,",
                 powers_checked, operands_taken, field_writes);
        $display("including %0d degenerate-modulus and %0d zero-exponent operations.",
                 bad_modulus_seen, zero_exponent_seen);
        if (mismatches == 0 && orphans == 0 && expected_powers.size() == 0) begin
            $display("tb_gf2n_modular_exponentiation OK");
        end else begin
            $display("%0d mismatches, %0d unexpected results, %0d missing results",
                     mismatches, orphans, expected_powers.size());
            $display("tb_gf2n_modular_exponentiation NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400_000_000;
        $display("Timeout with %0d results outstanding", expected_powers.size());
        $display("tb_gf2n_modular_exponentiation NOT OK");
        $finish;
    end

endmodule
